FILE: rtl/gru_pkg.sv
// shared constants, types and arithmetic helpers for the rank-one update block
`default_nettype none
package gru_pkg;

	localparam int SITES = 16;
	localparam int SLICES = 8;
	localparam int FRAC_BITS = 24;

	localparam int DW = 32;
	localparam int IDX_W = $clog2(SITES);
	localparam int CP_W = IDX_W + 1;
	localparam int ADDR_W = $clog2(SLICES * SITES * SITES);
	localparam int A_W = DW + 1;
	localparam int P_W = A_W + DW;
	localparam int W_W = P_W + 1;
	localparam int DIV_W = DW + FRAC_BITS + 1;
	localparam int DCNT_W = $clog2(DIV_W);

	localparam logic signed [A_W-1:0] ONE_A = A_W'(1) <<< FRAC_BITS;
	localparam logic signed [W_W-1:0] MAX_W = W_W'(2147483647);
	localparam logic signed [W_W-1:0] MIN_W = -MAX_W - W_W'(1);

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ = 2'd1;
	localparam logic [1:0] OP_UPDATE = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	localparam logic [1:0] RD_ITEM = 2'd0;
	localparam logic [1:0] RD_GSS = 2'd1;
	localparam logic [1:0] RD_COPY = 2'd2;
	localparam logic [1:0] RD_ENT = 2'd3;

	localparam logic [1:0] MS_RATIO = 2'd0;
	localparam logic [1:0] MS_T = 2'd1;
	localparam logic [1:0] MS_ENT = 2'd2;

	typedef struct packed {
		logic [1:0] operation;
		logic [2:0] slice;
		logic [3:0] row;
		logic [3:0] col;
		logic [31:0] value;
		logic [3:0] site;
		logic [31:0] delta;
	} item_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic [31:0] ratio;
		logic [1:0] status;
	} result_t;

	typedef struct packed {
		logic capture;
		logic wr_item;
		logic rd_en;
		logic [1:0] rd_sel;
		logic cap_read;
		logic mul_en;
		logic [1:0] mul_sel;
		logic ratio_fin;
		logic div_init;
		logic div_step;
		logic pref_fin;
		logic t_fin;
		logic result_load;
		logic [CP_W-1:0] k;
		logic [IDX_W-1:0] i;
		logic [IDX_W-1:0] j;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic addr_ok;
		logic site_ok;
		logic ratio_zero;
	} sts_t;

	typedef struct packed {
		logic sat;
		logic [DW-1:0] v;
	} sat_t;

	// divide by 2^FRAC_BITS, round half away from zero
	function automatic logic signed [P_W-1:0] scale_down(input logic signed [P_W-1:0] x);
		logic [P_W-1:0] mag;
		logic [P_W-1:0] r;
		mag = x[P_W-1] ? P_W'(-x) : P_W'(x);
		r = (mag + (P_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		return x[P_W-1] ? -$signed(r) : $signed(r);
	endfunction

	function automatic sat_t sat32(input logic signed [W_W-1:0] v);
		sat_t r;
		if (v > MAX_W) begin
			r.sat = 1'b1;
			r.v = MAX_W[DW-1:0];
		end else if (v < MIN_W) begin
			r.sat = 1'b1;
			r.v = MIN_W[DW-1:0];
		end else begin
			r.sat = 1'b0;
			r.v = v[DW-1:0];
		end
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] addr_of(input int sl, input int r, input int c);
		return ADDR_W'((sl * SITES + r) * SITES + c);
	endfunction

endpackage
`default_nettype wire

FILE: rtl/gru_ifs.sv
// request and response channel interfaces
`default_nettype none
interface gru_req_if;
	logic valid;
	logic ready;
	logic [1:0] operation;
	logic [2:0] slice;
	logic [3:0] row;
	logic [3:0] col;
	logic signed [31:0] value;
	logic [3:0] site;
	logic signed [31:0] delta;
	modport source (output valid, operation, slice, row, col, value, site, delta, input ready);
	modport sink (input valid, operation, slice, row, col, value, site, delta, output ready);
endinterface

interface gru_rsp_if;
	logic valid;
	logic ready;
	logic signed [31:0] read_value;
	logic signed [31:0] ratio;
	logic [1:0] status;
	modport source (output valid, read_value, ratio, status, input ready);
	modport sink (input valid, read_value, ratio, status, output ready);
endinterface
`default_nettype wire

FILE: rtl/gru_dp.sv
// datapath: matrix store, shared multiplier, divider, row and column copies
`default_nettype none
module gru_dp import gru_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire item_t item,
	input wire cmd_t cmd,
	output sts_t sts,
	output result_t result
);

	localparam logic [DIV_W-1:0] Q_POS_MAX = DIV_W'(64'h7FFF_FFFF);
	localparam logic [DIV_W-1:0] Q_NEG_MAX = DIV_W'(64'h8000_0000);

	logic [DW-1:0] mem [SLICES*SITES*SITES];
	logic [DW-1:0] rdata_q;

	logic [1:0] op_q;
	logic [2:0] slice_q;
	logic [3:0] row_q;
	logic [3:0] col_q;
	logic [DW-1:0] value_q;
	logic [3:0] site_q;
	logic [DW-1:0] delta_q;
	logic addr_ok_q;
	logic site_ok_q;

	logic [DW-1:0] rdval_q;
	logic [DW-1:0] ratio_q;
	logic sat_q;
	logic [DW-1:0] pref_q;
	logic [DW-1:0] t_q;
	logic signed [P_W-1:0] prod_q;
	logic neg_q;
	logic [DW-1:0] den_q;
	logic [DW:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DW-1:0] colc_q [SITES];
	logic [DW-1:0] rowc_q [SITES];
	result_t result_q;

	logic cp_v_s1;
	logic cp_row_s1;
	logic [IDX_W-1:0] cp_idx_s1;
	logic en_v_s1;
	logic [ADDR_W-1:0] en_addr_s1;

	logic [ADDR_W-1:0] ra;
	logic [ADDR_W-1:0] wa;
	logic [DW-1:0] wd;
	logic we;
	logic signed [A_W-1:0] ma;
	logic signed [DW-1:0] mb;
	logic [DW-1:0] dabs;
	logic [DW-1:0] rabs;
	logic [DW+1:0] sh;
	logic sub_ok;
	sat_t s_ratio;
	sat_t s_t;
	sat_t s_e;
	sat_t s_diag;
	logic pref_sat;
	logic [DW-1:0] pref_v;
	logic sat_nxt;
	logic [1:0] st_code;

	assign sts = '{op: op_q, addr_ok: addr_ok_q, site_ok: site_ok_q,
		ratio_zero: (ratio_q == '0)};
	assign result = result_q;

	// read address
	always_comb begin
		case (cmd.rd_sel)
			RD_ITEM: ra = addr_of(int'(slice_q), int'(row_q), int'(col_q));
			RD_GSS: ra = addr_of(int'(slice_q), int'(site_q), int'(site_q));
			RD_COPY: begin
				if (cmd.k[0])
					ra = addr_of(int'(slice_q), int'(site_q), int'(cmd.k[CP_W-1:1]));
				else
					ra = addr_of(int'(slice_q), int'(cmd.k[CP_W-1:1]), int'(site_q));
			end
			default: ra = addr_of(int'(slice_q), int'(cmd.i), int'(cmd.j));
		endcase
	end

	// entry writeback
	assign s_e = sat32(W_W'($signed(rdata_q)) + W_W'(scale_down(prod_q)));
	assign s_diag = sat32(W_W'($signed(rdata_q)) - W_W'(ONE_A));

	always_comb begin
		if (en_v_s1) begin
			we = 1'b1;
			wa = en_addr_s1;
			wd = s_e.v;
		end else begin
			we = cmd.wr_item;
			wa = addr_of(int'(slice_q), int'(row_q), int'(col_q));
			wd = value_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		if (cmd.rd_en)
			rdata_q <= mem[ra];
	end

	// shared multiplier
	always_comb begin
		case (cmd.mul_sel)
			MS_RATIO: begin
				ma = ONE_A - $signed({rdata_q[DW-1], rdata_q});
				mb = $signed(delta_q);
			end
			MS_T: begin
				ma = $signed({pref_q[DW-1], pref_q});
				mb = $signed(colc_q[cmd.i]);
			end
			default: begin
				ma = $signed({t_q[DW-1], t_q});
				mb = $signed(rowc_q[cmd.j]);
			end
		endcase
	end

	assign s_ratio = sat32(W_W'(ONE_A) + W_W'(scale_down(prod_q)));
	assign s_t = sat32(W_W'(scale_down(prod_q)));

	// divider operands and step
	assign dabs = delta_q[DW-1] ? DW'(-$signed(delta_q)) : delta_q;
	assign rabs = ratio_q[DW-1] ? DW'(-$signed(ratio_q)) : ratio_q;
	assign sh = {rem_q, quo_q[DIV_W-1]};
	assign sub_ok = sh >= {2'b00, den_q};

	always_comb begin
		if (!neg_q) begin
			pref_sat = quo_q > Q_POS_MAX;
			pref_v = pref_sat ? MAX_W[DW-1:0] : quo_q[DW-1:0];
		end else begin
			pref_sat = quo_q > Q_NEG_MAX;
			pref_v = pref_sat ? MIN_W[DW-1:0] : DW'(-$signed(quo_q[DW-1:0]));
		end
	end

	always_comb begin
		sat_nxt = sat_q;
		if (cmd.ratio_fin && s_ratio.sat)
			sat_nxt = 1'b1;
		if (cmd.pref_fin && pref_sat)
			sat_nxt = 1'b1;
		if (cmd.t_fin && s_t.sat)
			sat_nxt = 1'b1;
		if (en_v_s1 && s_e.sat)
			sat_nxt = 1'b1;
		if (cp_v_s1 && cp_row_s1 && int'(cp_idx_s1) == int'(site_q) && s_diag.sat)
			sat_nxt = 1'b1;
	end

	always_comb begin
		st_code = ST_OK;
		if (op_q == OP_UPDATE && site_ok_q) begin
			if (ratio_q == '0)
				st_code = ST_ZERO;
			else if (sat_q)
				st_code = ST_SAT;
		end
	end

	// pipeline tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_v_s1 <= 1'b0;
			en_v_s1 <= 1'b0;
		end else begin
			cp_v_s1 <= cmd.rd_en && cmd.rd_sel == RD_COPY;
			en_v_s1 <= cmd.rd_en && cmd.rd_sel == RD_ENT;
		end
	end

	always_ff @(posedge clk) begin
		cp_row_s1 <= cmd.k[0];
		cp_idx_s1 <= cmd.k[CP_W-1:1];
		en_addr_s1 <= ra;
		if (cmd.capture) begin
			op_q <= item.operation;
			slice_q <= item.slice;
			row_q <= item.row;
			col_q <= item.col;
			value_q <= item.value;
			site_q <= item.site;
			delta_q <= item.delta;
			addr_ok_q <= int'(item.slice) < SLICES && int'(item.row) < SITES
				&& int'(item.col) < SITES;
			site_ok_q <= int'(item.slice) < SLICES && int'(item.site) < SITES;
			rdval_q <= '0;
			ratio_q <= '0;
			sat_q <= 1'b0;
		end else begin
			sat_q <= sat_nxt;
			if (cmd.cap_read)
				rdval_q <= rdata_q;
			if (cmd.ratio_fin)
				ratio_q <= s_ratio.v;
		end
		if (cmd.mul_en)
			prod_q <= ma * mb;
		if (cmd.div_init) begin
			neg_q <= delta_q[DW-1] ^ ratio_q[DW-1];
			den_q <= rabs;
			rem_q <= '0;
			quo_q <= (DIV_W'(dabs) << FRAC_BITS) + DIV_W'(rabs >> 1);
		end else if (cmd.div_step) begin
			rem_q <= sub_ok ? (DW+1)'(sh - {2'b00, den_q}) : sh[DW:0];
			quo_q <= {quo_q[DIV_W-2:0], sub_ok};
		end
		if (cmd.pref_fin)
			pref_q <= pref_v;
		if (cmd.t_fin)
			t_q <= s_t.v;
		if (cp_v_s1) begin
			if (cp_row_s1)
				rowc_q[cp_idx_s1] <= (int'(cp_idx_s1) == int'(site_q)) ? s_diag.v : rdata_q;
			else
				colc_q[cp_idx_s1] <= rdata_q;
		end
		if (cmd.result_load)
			result_q <= '{read_value: rdval_q, ratio: ratio_q, status: st_code};
	end

endmodule
`default_nettype wire

FILE: rtl/gru_ctrl.sv
// controller: sequences one item through the datapath
`default_nettype none
module gru_ctrl import gru_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	input wire sts_t sts,
	output cmd_t cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DISP = 4'd1;
	localparam logic [3:0] S_RDW = 4'd2;
	localparam logic [3:0] S_GSS = 4'd3;
	localparam logic [3:0] S_RATIO = 4'd4;
	localparam logic [3:0] S_CHECK = 4'd5;
	localparam logic [3:0] S_DIV = 4'd6;
	localparam logic [3:0] S_PREF = 4'd7;
	localparam logic [3:0] S_COPY = 4'd8;
	localparam logic [3:0] S_COPYW = 4'd9;
	localparam logic [3:0] S_TMUL = 4'd10;
	localparam logic [3:0] S_TFIN = 4'd11;
	localparam logic [3:0] S_ENT = 4'd12;
	localparam logic [3:0] S_DRAIN = 4'd13;
	localparam logic [3:0] S_DONE = 4'd14;

	logic [3:0] state_q;
	logic [3:0] state_nxt;
	logic [CP_W-1:0] k_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic ov_q;
	logic k_last;
	logic i_last;
	logic j_last;
	logic d_last;

	assign k_last = k_q == CP_W'(2 * SITES - 1);
	assign i_last = i_q == IDX_W'(SITES - 1);
	assign j_last = j_q == IDX_W'(SITES - 1);
	assign d_last = dcnt_q == DCNT_W'(DIV_W - 1);
	assign in_ready = state_q == S_IDLE;
	assign out_valid = ov_q;

	always_comb begin
		cmd = '0;
		cmd.k = k_q;
		cmd.i = i_q;
		cmd.j = j_q;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt = S_DISP;
				end
			end
			S_DISP: begin
				state_nxt = S_DONE;
				case (sts.op)
					OP_WRITE: cmd.wr_item = sts.addr_ok;
					OP_READ: begin
						if (sts.addr_ok) begin
							cmd.rd_en = 1'b1;
							cmd.rd_sel = RD_ITEM;
							state_nxt = S_RDW;
						end
					end
					OP_UPDATE: begin
						if (sts.site_ok) begin
							cmd.rd_en = 1'b1;
							cmd.rd_sel = RD_GSS;
							state_nxt = S_GSS;
						end
					end
					default: state_nxt = S_DONE;
				endcase
			end
			S_RDW: begin
				cmd.cap_read = 1'b1;
				state_nxt = S_DONE;
			end
			S_GSS: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MS_RATIO;
				state_nxt = S_RATIO;
			end
			S_RATIO: begin
				cmd.ratio_fin = 1'b1;
				state_nxt = S_CHECK;
			end
			S_CHECK: begin
				if (sts.ratio_zero) begin
					state_nxt = S_DONE;
				end else begin
					cmd.div_init = 1'b1;
					state_nxt = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (d_last)
					state_nxt = S_PREF;
			end
			S_PREF: begin
				cmd.pref_fin = 1'b1;
				state_nxt = S_COPY;
			end
			S_COPY: begin
				cmd.rd_en = 1'b1;
				cmd.rd_sel = RD_COPY;
				if (k_last)
					state_nxt = S_COPYW;
			end
			S_COPYW: state_nxt = S_TMUL;
			S_TMUL: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MS_T;
				state_nxt = S_TFIN;
			end
			S_TFIN: begin
				cmd.t_fin = 1'b1;
				state_nxt = S_ENT;
			end
			S_ENT: begin
				cmd.rd_en = 1'b1;
				cmd.rd_sel = RD_ENT;
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MS_ENT;
				if (j_last)
					state_nxt = i_last ? S_DRAIN : S_TMUL;
			end
			S_DRAIN: state_nxt = S_DONE;
			S_DONE: begin
				if (!ov_q || out_ready) begin
					cmd.result_load = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q <= '0;
			i_q <= '0;
			j_q <= '0;
			dcnt_q <= '0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.div_init)
				dcnt_q <= '0;
			else if (cmd.div_step)
				dcnt_q <= dcnt_q + 1'b1;
			if (cmd.pref_fin)
				k_q <= '0;
			else if (state_q == S_COPY)
				k_q <= k_q + 1'b1;
			if (state_q == S_COPYW)
				i_q <= '0;
			else if (state_q == S_ENT && j_last)
				i_q <= i_q + 1'b1;
			if (cmd.t_fin)
				j_q <= '0;
			else if (state_q == S_ENT)
				j_q <= j_q + 1'b1;
			if (cmd.result_load)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/green_rank_one_update_top.sv
// Green's-function store with entry access and Sherman-Morrison rank-one update.
// One item at a time; entries, delta and ratio are Q7.24. The single read port of
// the matrix memory paces the copy and update sweeps, and the prefactor comes from a
// divider that yields one quotient bit per cycle. A zero ratio ends the update
// before the division. The result register lets the next item be taken while a
// result still waits.
`default_nettype none
module green_rank_one_update_top import gru_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	gru_req_if.sink req,
	gru_rsp_if.source rsp
);

	item_t item;
	result_t result;
	cmd_t cmd;
	sts_t sts;

	assign item = '{operation: req.operation, slice: req.slice, row: req.row, col: req.col,
		value: req.value, site: req.site, delta: req.delta};
	assign rsp.read_value = result.read_value;
	assign rsp.ratio = result.ratio;
	assign rsp.status = result.status;

	gru_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.sts(sts),
		.cmd(cmd)
	);

	gru_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.cmd(cmd),
		.sts(sts),
		.result(result)
	);

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("second transfer taken while an item is in work");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_init |-> !sts.ratio_zero)
		else $error("division started with zero ratio");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result_load |=> rsp.valid)
		else $error("loaded result not presented");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result_load |-> !rsp.valid || rsp.ready)
		else $error("result overwritten before transfer");

endmodule
`default_nettype wire

FILE: verif/green_rank_one_update_top_test.sv
// testbench for the green's-function rank-one update block: directed table plus random fills and mixed items
`timescale 1ns / 1ps
`default_nettype none
module green_rank_one_update_top_test;
	import gru_pkg::*;

	localparam longint ONE_Q = longint'(1) <<< FRAC_BITS;
	localparam longint HI32 = 64'sd2147483647;
	localparam longint LO32 = -64'sd2147483648;
	localparam int IDLE_LIMIT = 5000;
	localparam int ITEM_GOAL = 1800;

	typedef struct {
		item_t it;
		bit chk;
		result_t res;
	} row_t;

	logic clk;
	logic arst_n;
	gru_req_if req_ch();
	gru_rsp_if rsp_ch();

	green_rank_one_update_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	int green_mem [SLICES][SITES][SITES];
	bit written [SLICES][SITES][SITES];
	result_t pending_q [$];
	int errors = 0;
	int items_sent = 0;
	int burst_left = 0;
	int idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint scale_q(input longint x);
		longint m;
		m = x < 0 ? -x : x;
		m = (m + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		return x < 0 ? -m : m;
	endfunction

	function automatic longint clamp32(input longint v, inout bit flag);
		if (v > HI32) begin
			flag = 1'b1;
			return HI32;
		end
		if (v < LO32) begin
			flag = 1'b1;
			return LO32;
		end
		return v;
	endfunction

	function automatic result_t green_step(input item_t it);
		result_t r;
		bit sat;
		longint gss, dl, rat, num, den, q, pref, t, e;
		longint colc [SITES];
		longint rowc [SITES];
		int sl, s;
		r = '{32'd0, 32'd0, ST_OK};
		sat = 1'b0;
		sl = it.slice;
		s = it.site;
		if (it.operation == OP_WRITE) begin
			green_mem[sl][it.row][it.col] = $signed(it.value);
			written[sl][it.row][it.col] = 1'b1;
		end else if (it.operation == OP_READ) begin
			r.read_value = green_mem[sl][it.row][it.col];
		end else if (it.operation == OP_UPDATE) begin
			gss = green_mem[sl][s][s];
			dl = longint'($signed(it.delta));
			rat = clamp32(ONE_Q + scale_q((ONE_Q - gss) * dl), sat);
			if (rat == 0) begin
				r.status = ST_ZERO;
			end else begin
				num = (dl < 0 ? -dl : dl) <<< FRAC_BITS;
				den = rat < 0 ? -rat : rat;
				q = (num + den / 2) / den;
				if (q > (longint'(1) <<< 32))
					q = longint'(1) <<< 32;
				pref = clamp32(((dl < 0) != (rat < 0)) ? -q : q, sat);
				for (int i = 0; i < SITES; i++) begin
					colc[i] = green_mem[sl][i][s];
					rowc[i] = green_mem[sl][s][i];
				end
				rowc[s] = clamp32(rowc[s] - ONE_Q, sat);
				for (int i = 0; i < SITES; i++) begin
					t = clamp32(scale_q(pref * colc[i]), sat);
					for (int j = 0; j < SITES; j++) begin
						e = longint'(green_mem[sl][i][j]) + scale_q(t * rowc[j]);
						green_mem[sl][i][j] = int'(clamp32(e, sat));
					end
				end
			end
			r.ratio = rat[31:0];
			if (sat && r.status == ST_OK)
				r.status = ST_SAT;
		end
		return r;
	endfunction

	function automatic item_t mk(input logic [1:0] op, input int sl, input int rw, input int cl,
			input logic [31:0] v, input int s, input logic [31:0] d);
		item_t it;
		it.operation = op;
		it.slice = sl[2:0];
		it.row = rw[3:0];
		it.col = cl[3:0];
		it.value = v;
		it.site = s[3:0];
		it.delta = d;
		return it;
	endfunction

	function automatic logic [31:0] rand_q(input bit tame);
		case ($urandom_range(0, tame ? 1 : 3))
			0: return 32'($signed($urandom_range(0, 2 * (1 << 22))) - (1 << 22));
			1: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
			2: return $urandom;
			default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
		endcase
	endfunction

	task automatic send(input item_t it, input bit chk, input result_t typed);
		result_t p;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0)
				req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 20);
		end
		req_ch.valid <= 1'b1;
		req_ch.operation <= it.operation;
		req_ch.slice <= it.slice;
		req_ch.row <= it.row;
		req_ch.col <= it.col;
		req_ch.value <= it.value;
		req_ch.site <= it.site;
		req_ch.delta <= it.delta;
		do @(posedge clk); while (!req_ch.ready);
		p = green_step(it);
		pending_q.push_back(chk ? typed : p);
		burst_left--;
		items_sent++;
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic fill_slice(input int sl, input bit wild);
		logic [31:0] v;
		for (int i = 0; i < SITES; i++)
			for (int j = 0; j < SITES; j++) begin
				v = rand_q(!wild);
				if (i == j && !wild && $urandom_range(0, 1))
					v = 32'($signed($urandom_range(0, 1 << 25)) - (1 << 23));
				send(mk(OP_WRITE, sl, i, j, v, $urandom_range(0, 15), $urandom), 1'b0, '0);
			end
	endtask

	// receiver is ready through the first part of each repeating pattern and stalls at random in the rest
	int stall_phase = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_phase <= 0;
		end else begin
			stall_phase <= (stall_phase + 1) % 37;
			if (stall_phase < 12)
				rsp_ch.ready <= 1'b1;
			else
				rsp_ch.ready <= ($urandom_range(0, 2) != 0);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result read_value=%h ratio=%h status=%0d", $time,
					rsp_ch.read_value, rsp_ch.ratio, rsp_ch.status);
				errors++;
			end else begin
				want = pending_q.pop_front();
				if (rsp_ch.read_value !== want.read_value) begin
					$display("%0t: read_value expected %h actual %h", $time, want.read_value,
						rsp_ch.read_value);
					errors++;
				end
				if (rsp_ch.ratio !== want.ratio) begin
					$display("%0t: ratio expected %h actual %h", $time, want.ratio, rsp_ch.ratio);
					errors++;
				end
				if (rsp_ch.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status,
						rsp_ch.status);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		row_t dir_tab [$];
		item_t it;
		int sl, s, rw, cl;
		req_ch.valid = 1'b0;
		req_ch.operation = OP_WRITE;
		req_ch.slice = '0;
		req_ch.row = '0;
		req_ch.col = '0;
		req_ch.value = '0;
		req_ch.site = '0;
		req_ch.delta = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		fill_slice(0, 1'b0);

		dir_tab.push_back('{mk(OP_WRITE, 1, 0, 0, 32'h7fffffff, 0, 0), 1'b1, '{0, 0, ST_OK}});
		dir_tab.push_back('{mk(OP_WRITE, 1, 15, 15, 32'h80000000, 15, 32'hffffffff), 1'b1,
			'{0, 0, ST_OK}});
		dir_tab.push_back('{mk(OP_WRITE, 1, 15, 0, 32'h0, 0, 0), 1'b1, '{0, 0, ST_OK}});
		dir_tab.push_back('{mk(OP_READ, 1, 0, 0, 0, 0, 0), 1'b1, '{32'h7fffffff, 0, ST_OK}});
		dir_tab.push_back('{mk(OP_READ, 1, 15, 15, 32'hffffffff, 15, 32'hffffffff), 1'b1,
			'{32'h80000000, 0, ST_OK}});
		dir_tab.push_back('{mk(OP_READ, 1, 15, 0, 0, 0, 0), 1'b1, '{0, 0, ST_OK}});
		dir_tab.push_back('{mk(2'd3, 7, 15, 15, 32'hffffffff, 15, 32'hffffffff), 1'b1,
			'{0, 0, ST_OK}});
		dir_tab.push_back('{mk(2'd3, 0, 0, 0, 0, 0, 0), 1'b1, '{0, 0, ST_OK}});
		dir_tab.push_back('{mk(OP_WRITE, 0, 3, 3, 32'h0, 0, 0), 1'b1, '{0, 0, ST_OK}});
		// zero ratio: gss = 0 and delta = -1.0
		dir_tab.push_back('{mk(OP_UPDATE, 0, 0, 0, 0, 3, 32'hff000000), 1'b1,
			'{0, 0, ST_ZERO}});
		// delta zero leaves the matrix as is
		dir_tab.push_back('{mk(OP_UPDATE, 0, 0, 0, 0, 3, 32'h0), 1'b1,
			'{0, 32'h01000000, ST_OK}});
		dir_tab.push_back('{mk(OP_READ, 0, 3, 3, 0, 0, 0), 1'b1, '{0, 0, ST_OK}});
		dir_tab.push_back('{mk(OP_UPDATE, 0, 0, 0, 0, 0, 32'h00400000), 1'b0, '0});
		dir_tab.push_back('{mk(OP_UPDATE, 0, 0, 0, 0, 15, 32'hffc00000), 1'b0, '0});
		dir_tab.push_back('{mk(OP_UPDATE, 0, 0, 0, 0, 7, 32'h7fffffff), 1'b0, '0});
		dir_tab.push_back('{mk(OP_UPDATE, 0, 0, 0, 0, 8, 32'h80000000), 1'b0, '0});
		dir_tab.push_back('{mk(OP_READ, 0, 15, 0, 0, 0, 0), 1'b0, '0});
		dir_tab.push_back('{mk(OP_READ, 0, 0, 15, 0, 0, 0), 1'b0, '0});
		dir_tab.push_back('{mk(OP_READ, 0, 8, 8, 0, 0, 0), 1'b0, '0});

		foreach (dir_tab[n])
			send(dir_tab[n].it, dir_tab[n].chk, dir_tab[n].res);

		while (items_sent + SITES * SITES + 40 <= ITEM_GOAL) begin
			drain();
			sl = $urandom_range(0, SLICES - 1);
			fill_slice(sl, $urandom_range(0, 5) == 0);
			repeat (40) begin
				rw = $urandom_range(0, 15);
				cl = $urandom_range(0, 15);
				s = $urandom_range(0, 15);
				case ($urandom_range(0, 9))
					0, 1: it = mk(OP_WRITE, sl, rw, cl, rand_q($urandom_range(0, 3) != 0), s,
						$urandom);
					2, 3, 4: it = mk(OP_READ, sl, rw, cl, $urandom, s, $urandom);
					5, 6, 7: it = mk(OP_UPDATE, sl, rw, cl, $urandom, s,
						rand_q($urandom_range(0, 4) != 0));
					8: begin
						it = mk($urandom_range(0, 1) ? OP_READ : OP_WRITE,
							$urandom_range(0, SLICES - 1), rw, cl, $urandom, s, $urandom);
						if (!written[it.slice][rw][cl])
							it.operation = OP_WRITE;
					end
					default: it = mk(2'd3, $urandom_range(0, 7), rw, cl, $urandom, s, $urandom);
				endcase
				send(it, 1'b0, '0);
			end
		end

		drain();
		repeat (400) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire
